// File: rtl/core/tlhm_pkg.sv
// Shared types, constants and codes for the telemetry link health monitor.
`timescale 1ns / 1ps

package tlhm_pkg;

  localparam int SEQ_BITS   = 32;
  localparam int COUNT_BITS = 32;

  localparam logic [7:0]  RUN_MAX           = 8'd255;
  localparam logic [15:0] MAGIC_RESET       = 16'd0;
  localparam logic [7:0]  VERSION_RESET     = 8'd0;
  localparam logic [7:0]  THRESHOLD_RESET   = 8'd3;
  localparam logic [31:0] MAX_AGE_RESET     = 32'd1000000;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPECTED_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPECTED_VERSION = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_THRESHOLD   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRESH_LIMIT      = 2'd3;
  localparam int CFG_DATA_BITS = 32;

  // link modes as reported on the result channel
  localparam logic [1:0] MODE_DOWN     = 2'd0;
  localparam logic [1:0] MODE_DEGRADED = 2'd1;
  localparam logic [1:0] MODE_LIVE     = 2'd2;

  // outcome of the ordered poll checks
  typedef enum logic [2:0] {
    POLL_OK        = 3'd0,
    POLL_IDENT_ERR = 3'd1,
    POLL_ID_BAD    = 3'd2,
    POLL_TELEM_ERR = 3'd3,
    POLL_CRC_ERR   = 3'd4,
    POLL_SEQ_STALL = 3'd5
  } poll_outcome_t;

  typedef struct packed {
    logic        ident_read_ok;
    logic [15:0] peer_magic;
    logic [7:0]  peer_version;
    logic        telem_read_ok;
    logic        crc_match;
    logic [31:0] frame_seq;
    logic [47:0] now_time;
  } tlhm_in_t;

  typedef struct packed {
    logic [1:0]  link_mode;
    logic        is_fresh;
    logic [7:0]  fail_run_out;
    logic [31:0] poll_total_out;
    logic [31:0] timeout_total_out;
    logic [31:0] crc_error_total_out;
  } tlhm_out_t;

  typedef struct packed {
    logic [15:0] expected_magic;
    logic [7:0]  expected_version;
    logic [7:0]  down_threshold;
    logic [31:0] fresh_limit;
  } tlhm_cfg_t;

endpackage

// File: rtl/core/telemetry_link_health_monitor.sv
// Top level of the telemetry link health monitor.
//
// One request on the in_ channel is the outcome of one poll of the peer.
// Each request yields exactly one result on the out_ channel: link mode,
// freshness of the last good frame, the failure run and the running
// poll, timeout and CRC error counters as they stand after that poll.
// A request taken at one edge is held in the input register, evaluated
// there against the link state and moved into the result register, and
// so onto out_, as soon as the result register is free or being taken.
// Throughput is one request per cycle while out_stall is low; the only
// loop is the link state register update through its next-state logic.
// in_stall is raised only when both the input register and the result
// register hold requests and the receiver stalls, so the block keeps
// taking requests while one finished result waits. A stalled result
// holds its payload until it is taken.
// Reset (synchronous, rst_n low) empties both registers, sets the link
// DOWN, clears all counters and loads the configuration defaults.
// cfg_ writes take effect at once and belong between polls only.
`timescale 1ns / 1ps

module telemetry_link_health_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tlhm_pkg::tlhm_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tlhm_pkg::tlhm_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [tlhm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tlhm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tlhm_pkg::*;

  tlhm_cfg_t cfg;
  tlhm_out_t result;

  logic      in_valid_r,  in_valid_nxt;
  tlhm_in_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  tlhm_out_t out_data_r;

  logic s1_ready;
  logic s2_ready;
  logic advance;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !in_valid_r || s2_ready;
  assign advance  = in_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  tlhm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlhm_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (in_item_r),
    .advance (advance),
    .result  (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (s1_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/tlhm_cfg.sv
// Configuration register file of the telemetry link health monitor.
`timescale 1ns / 1ps

module tlhm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlhm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tlhm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output tlhm_pkg::tlhm_cfg_t              cfg
);
  import tlhm_pkg::*;

  tlhm_cfg_t cfg_r;
  tlhm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_MAGIC:   cfg_nxt.expected_magic   = cfg_data[15:0];
        CFG_EXPECTED_VERSION: cfg_nxt.expected_version = cfg_data[7:0];
        CFG_DOWN_THRESHOLD:   cfg_nxt.down_threshold   = cfg_data[7:0];
        CFG_FRESH_LIMIT:      cfg_nxt.fresh_limit      = cfg_data[31:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= MAGIC_RESET;
      cfg_r.expected_version <= VERSION_RESET;
      cfg_r.down_threshold   <= THRESHOLD_RESET;
      cfg_r.fresh_limit      <= MAX_AGE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/tlhm_state.sv
// Poll checks, link state registers and result formation.
`timescale 1ns / 1ps

module tlhm_state (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlhm_pkg::tlhm_cfg_t  cfg,
  input  tlhm_pkg::tlhm_in_t   item,
  input  logic                 advance,
  output tlhm_pkg::tlhm_out_t  result
);
  import tlhm_pkg::*;

  logic [1:0]            mode_r,         mode_nxt;
  logic [7:0]            fail_run_r,     fail_run_nxt;
  logic                  had_good_r,     had_good_nxt;
  logic [SEQ_BITS-1:0]   last_seq_r,     last_seq_nxt;
  logic [47:0]           last_time_r,    last_time_nxt;
  logic [COUNT_BITS-1:0] poll_total_r,   poll_total_nxt;
  logic [COUNT_BITS-1:0] timeout_total_r, timeout_total_nxt;
  logic [COUNT_BITS-1:0] crc_total_r,    crc_total_nxt;

  poll_outcome_t       outcome;
  logic [SEQ_BITS-1:0] seq;
  logic [7:0]          run_inc;
  logic [47:0]         age;
  logic                fresh;

  assign seq = item.frame_seq[SEQ_BITS-1:0];

  // first failing check wins
  always_comb begin
    if (!item.ident_read_ok) begin
      outcome = POLL_IDENT_ERR;
    end else if (item.peer_magic != cfg.expected_magic ||
                 item.peer_version != cfg.expected_version) begin
      outcome = POLL_ID_BAD;
    end else if (!item.telem_read_ok) begin
      outcome = POLL_TELEM_ERR;
    end else if (!item.crc_match) begin
      outcome = POLL_CRC_ERR;
    end else if (had_good_r && seq == last_seq_r) begin
      outcome = POLL_SEQ_STALL;
    end else begin
      outcome = POLL_OK;
    end
  end

  assign run_inc = (fail_run_r == RUN_MAX) ? fail_run_r : fail_run_r + 8'd1;

  always_comb begin
    mode_nxt          = mode_r;
    fail_run_nxt      = fail_run_r;
    had_good_nxt      = had_good_r;
    last_seq_nxt      = last_seq_r;
    last_time_nxt     = last_time_r;
    poll_total_nxt    = poll_total_r + COUNT_BITS'(1);
    timeout_total_nxt = timeout_total_r;
    crc_total_nxt     = crc_total_r;

    if (outcome == POLL_OK) begin
      last_seq_nxt  = seq;
      last_time_nxt = item.now_time;
      had_good_nxt  = 1'b1;
      fail_run_nxt  = '0;
      mode_nxt      = MODE_LIVE;
    end else begin
      fail_run_nxt = run_inc;
      if (run_inc >= cfg.down_threshold) begin
        mode_nxt = MODE_DOWN;
      end else if (had_good_r) begin
        mode_nxt = MODE_DEGRADED;
      end else begin
        mode_nxt = MODE_DOWN;
      end
    end

    case (outcome)
      POLL_IDENT_ERR, POLL_TELEM_ERR, POLL_SEQ_STALL: begin
        timeout_total_nxt = timeout_total_r + COUNT_BITS'(1);
      end
      POLL_CRC_ERR: begin
        crc_total_nxt = crc_total_r + COUNT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  // freshness against the stored good frame; a success is age zero
  assign age = item.now_time - last_time_r;

  always_comb begin
    if (outcome == POLL_OK) begin
      fresh = 1'b1;
    end else if (!had_good_r) begin
      fresh = 1'b0;
    end else if (item.now_time < last_time_r) begin
      fresh = 1'b1;
    end else begin
      fresh = (age <= {16'd0, cfg.fresh_limit});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_DOWN;
      fail_run_r      <= '0;
      had_good_r      <= 1'b0;
      last_seq_r      <= '0;
      last_time_r     <= '0;
      poll_total_r    <= '0;
      timeout_total_r <= '0;
      crc_total_r     <= '0;
    end else if (advance) begin
      mode_r          <= mode_nxt;
      fail_run_r      <= fail_run_nxt;
      had_good_r      <= had_good_nxt;
      last_seq_r      <= last_seq_nxt;
      last_time_r     <= last_time_nxt;
      poll_total_r    <= poll_total_nxt;
      timeout_total_r <= timeout_total_nxt;
      crc_total_r     <= crc_total_nxt;
    end
  end

  always_comb begin
    result.link_mode           = mode_nxt;
    result.is_fresh            = fresh;
    result.fail_run_out        = fail_run_nxt;
    result.poll_total_out      = 32'(poll_total_nxt);
    result.timeout_total_out   = 32'(timeout_total_nxt);
    result.crc_error_total_out = 32'(crc_total_nxt);
  end

endmodule

// File: rtl/core/tlhm_checker.sv
// Port-level checks for the telemetry link health monitor, bound to the top level.
`timescale 1ns / 1ps

module tlhm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tlhm_pkg::tlhm_out_t out_data
);
  import tlhm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a zero failure run and a live link go together
  a_run_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.fail_run_out == 8'd0) == (out_data.link_mode == MODE_LIVE)))
    else $error("failure run and link mode disagree");

  // a live link has just taken a good frame, so it is fresh
  a_live_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.link_mode == MODE_LIVE |-> out_data.is_fresh)
    else $error("live link reported stale");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind telemetry_link_health_monitor tlhm_checker u_tlhm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
